### hdl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Each macro takes a label, the clock, the reset (active low), the
// antecedent, the consequent and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/kas_pkg.sv
// ----------------------------------------------------------------------------
// kas_pkg
// Shared types and constants of the keypad autorepeat scanner: field
// widths, register codes and the structs passed between lanes and merge.
// ----------------------------------------------------------------------------
package kas_pkg;

    // Field widths fixed by the stream payload.
    localparam int NUM_BUTTONS = 10;
    localparam int DUR_W       = 16;
    localparam int DELAY_W     = 7;

    // Packed stream widths, padded to whole bytes.
    localparam int IN_W  = 24;
    localparam int OUT_W = 40;

    // Configuration port.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_ENABLE  = 2'd0,
        REG_INITIAL = 2'd1,
        REG_REPEAT  = 2'd2,
        REG_MODE    = 2'd3
    } t_cfg_reg;

    // Autorepeat timing shared by all lanes.
    typedef struct packed {
        logic [DELAY_W-1:0] initial_delay;
        logic [DELAY_W-1:0] repeat_delay;
    } t_rep_cfg;

    // What one lane reports for the current transaction.
    typedef struct packed {
        logic             pulse;
        logic [DUR_W-1:0] duration;
    } t_lane_res;

endpackage

### hdl/kas_lane.sv
// ----------------------------------------------------------------------------
// kas_lane
// One button: hold-duration counter and autorepeat counter. Reports the
// updated duration and the autorepeat pulse of the transaction being taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kas_lane #(
    parameter int COUNTER_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic                i_down,
    input  logic                i_enable,
    input  kas_pkg::t_rep_cfg   i_cfg,
    output kas_pkg::t_lane_res  o_res
);

    localparam int CW = (COUNTER_BITS > kas_pkg::DELAY_W) ? COUNTER_BITS : kas_pkg::DELAY_W;
    localparam logic [COUNTER_BITS-1:0] FLAG = {1'b1, {(COUNTER_BITS-1){1'b0}}};

    logic [kas_pkg::DUR_W-1:0] r_dur;
    logic [kas_pkg::DUR_W-1:0] n_dur;
    logic [COUNTER_BITS-1:0]   r_cnt;
    logic [COUNTER_BITS-1:0]   n_cnt;
    logic [COUNTER_BITS-1:0]   cnt_inc;
    logic                      fire;

    // Next duration and autorepeat decision.
    always_comb begin
        n_dur   = i_down ? r_dur + 1'b1 : '0;
        cnt_inc = r_cnt + 1'b1;
        if (r_cnt[COUNTER_BITS-1]) begin
            fire = CW'(cnt_inc[COUNTER_BITS-2:0]) >= CW'(i_cfg.repeat_delay);
        end else begin
            fire = CW'(cnt_inc) >= CW'(i_cfg.initial_delay);
        end
        fire  = fire & i_down & i_enable;
        n_cnt = r_cnt;
        if (i_enable) begin
            if (!i_down) begin
                n_cnt = '0;
            end else if (fire) begin
                n_cnt = FLAG;
            end else begin
                n_cnt = cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur <= '0;
            r_cnt <= '0;
        end else if (i_advance) begin
            r_dur <= n_dur;
            r_cnt <= n_cnt;
        end
    end

    assign o_res.pulse    = fire;
    assign o_res.duration = n_dur;

    `ASSERT_NEXT(a_release_clears_cnt, i_clk, i_rst_n, i_advance && i_enable && !i_down, r_cnt == '0, "repeat counter not cleared on release")
    `ASSERT_NEXT(a_pulse_sets_flag, i_clk, i_rst_n, i_advance && fire, r_cnt == FLAG, "repeat counter not reloaded after pulse")
    `ASSERT_NEXT(a_release_clears_dur, i_clk, i_rst_n, i_advance && !i_down, r_dur == '0, "hold duration not cleared on release")

endmodule

### hdl/kas_merge.sv
// ----------------------------------------------------------------------------
// kas_merge
// Combines the lane results into one result transaction (edge mask ORed
// with autorepeat pulses, duration of the lowest queried button) and
// holds it in an output register backed by a skid register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kas_merge (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_advance,
    input  logic [kas_pkg::NUM_BUTTONS-1:0]                   i_held,
    input  logic [kas_pkg::NUM_BUTTONS-1:0]                   i_edge,
    input  logic [kas_pkg::NUM_BUTTONS-1:0]                   i_query,
    input  kas_pkg::t_lane_res [kas_pkg::NUM_BUTTONS-1:0]     i_res,
    output logic                                              o_ready,
    output logic                                              o_valid,
    input  logic                                              i_take_ready,
    output logic [kas_pkg::OUT_W-1:0]                         o_data
);

    localparam int NB = kas_pkg::NUM_BUTTONS;
    localparam int PAD_W = kas_pkg::OUT_W - 2 * NB - kas_pkg::DUR_W;

    logic [NB-1:0]              fresh;
    logic [kas_pkg::DUR_W-1:0]  qdur;
    logic [kas_pkg::OUT_W-1:0]  result;
    logic                       r_out_vld;
    logic                       n_out_vld;
    logic                       r_skid_vld;
    logic                       n_skid_vld;
    logic [kas_pkg::OUT_W-1:0]  r_out;
    logic [kas_pkg::OUT_W-1:0]  n_out;
    logic [kas_pkg::OUT_W-1:0]  r_skid;
    logic [kas_pkg::OUT_W-1:0]  n_skid;
    logic                       take;

    // Pulse merge and lowest-set-bit duration select.
    always_comb begin
        fresh = i_edge;
        qdur  = '0;
        for (int i = NB - 1; i >= 0; i--) begin
            fresh[i] = i_edge[i] | i_res[i].pulse;
            if (i_query[i]) begin
                qdur = i_res[i].duration;
            end
        end
        result = {{PAD_W{1'b0}}, qdur, fresh, i_held};
    end

    // Output register with skid stage.
    assign take = r_out_vld & i_take_ready;

    always_comb begin
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        n_out      = r_out;
        n_skid     = r_skid;
        if (r_skid_vld) begin
            if (take) begin
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end
        end else if (i_advance) begin
            if (!r_out_vld || take) begin
                n_out     = result;
                n_out_vld = 1'b1;
            end else begin
                n_skid     = result;
                n_skid_vld = 1'b1;
            end
        end else if (take) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_ready = ~r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    `ASSERT_NOW(a_skid_needs_out, i_clk, i_rst_n, r_skid_vld, r_out_vld, "skid entry without output entry")
    `ASSERT_NOW(a_new_within_held, i_clk, i_rst_n, r_out_vld, (r_out[2*NB-1:NB] & ~r_out[NB-1:0]) == '0, "new key not held")
    `ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_vld && take, r_out_vld && !r_skid_vld, "skid entry not moved to output")

endmodule

### hdl/key_autorepeat_scanner.sv
// Output: an accepted tick's result is registered in the output register, or in
// the skid register if the output is stalled. Throughput: one tick per cycle while
// the skid entry is free; lanes update in parallel, the skid absorbing one stall.
// Reset: synchronous, active low; clears registers, counters, delay line and
// the output stage.
// ----------------------------------------------------------------------------
// key_autorepeat_scanner
// Keypad scanner: inverts the active-low sample, optionally delays it, and
// reports held keys, new keys with autorepeat pulses and a queried duration.
// ----------------------------------------------------------------------------
module key_autorepeat_scanner #(
    parameter int COUNTER_BITS = 8,
    parameter int DELAY_STAGES = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kas_pkg::ADDR_W-1:0]  paddr,
    input  logic [kas_pkg::DATA_W-1:0]  pwdata,
    output logic [kas_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // Input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [kas_pkg::IN_W-1:0]    s_axis_tdata,  // raw_keys[9:0], query_mask[19:10]
    // Result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [kas_pkg::OUT_W-1:0]   m_axis_tdata   // held_keys[9:0], new_keys[19:10],
                                                       // queried_duration[35:20]
);

    localparam int NB = kas_pkg::NUM_BUTTONS;

    logic [NB-1:0]                      r_en_mask;
    kas_pkg::t_rep_cfg                  r_cfg;
    logic                               r_mode;
    logic [NB-1:0]                      r_prev_held;
    logic [NB-1:0]                      r_dline [DELAY_STAGES];
    logic                               cfg_wr;
    kas_pkg::t_cfg_reg                  cfg_sel;
    logic                               accept;
    logic [NB-1:0]                      sample;
    logic [NB-1:0]                      query;
    logic [NB-1:0]                      held;
    logic [NB-1:0]                      edge_mask;
    kas_pkg::t_lane_res [NB-1:0]        lane_res;

    // Configuration registers.
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_sel = kas_pkg::t_cfg_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_mask <= '0;
            r_cfg     <= '0;
            r_mode    <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                kas_pkg::REG_ENABLE:  r_en_mask           <= pwdata[NB-1:0];
                kas_pkg::REG_INITIAL: r_cfg.initial_delay <= pwdata[kas_pkg::DELAY_W-1:0];
                kas_pkg::REG_REPEAT:  r_cfg.repeat_delay  <= pwdata[kas_pkg::DELAY_W-1:0];
                kas_pkg::REG_MODE:    r_mode              <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_sel)
            kas_pkg::REG_ENABLE:  prdata[NB-1:0]               = r_en_mask;
            kas_pkg::REG_INITIAL: prdata[kas_pkg::DELAY_W-1:0] = r_cfg.initial_delay;
            kas_pkg::REG_REPEAT:  prdata[kas_pkg::DELAY_W-1:0] = r_cfg.repeat_delay;
            kas_pkg::REG_MODE:    prdata[0]                    = r_mode;
            default: ;
        endcase
    end

    // Input transaction and held mask.
    assign accept    = s_axis_tvalid & s_axis_tready;
    assign sample    = ~s_axis_tdata[NB-1:0];
    assign query     = s_axis_tdata[2*NB-1:NB];
    assign held      = r_mode ? r_dline[0] : sample;
    assign edge_mask = held & ~r_prev_held;

    // Delay line shifts only in delayed mode; oldest sample at index 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DELAY_STAGES; i++) begin
                r_dline[i] <= '0;
            end
            r_prev_held <= '0;
        end else if (accept) begin
            if (r_mode) begin
                for (int i = 0; i < DELAY_STAGES - 1; i++) begin
                    r_dline[i] <= r_dline[i+1];
                end
                r_dline[DELAY_STAGES-1] <= sample;
            end
            r_prev_held <= held;
        end
    end

    // One lane per button.
    for (genvar g = 0; g < NB; g++) begin : g_lane
        kas_lane #(
            .COUNTER_BITS (COUNTER_BITS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (accept),
            .i_down    (held[g]),
            .i_enable  (r_en_mask[g]),
            .i_cfg     (r_cfg),
            .o_res     (lane_res[g])
        );
    end

    kas_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (accept),
        .i_held       (held),
        .i_edge       (edge_mask),
        .i_query      (query),
        .i_res        (lane_res),
        .o_ready      (s_axis_tready),
        .o_valid      (m_axis_tvalid),
        .i_take_ready (m_axis_tready),
        .o_data       (m_axis_tdata)
    );

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb: keypad autorepeat scanner testbench
// Drives frame ticks into the scanner's input stream and sets its registers
// over the configuration port. A scoreboard model of the held mask, edge
// detection, autorepeat counters, hold timers and delay line predicts every
// result transaction. Each result is compared field by field in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Shared widths taken from the package.
    localparam int NUM_BUTTONS = kas_pkg::NUM_BUTTONS;
    localparam int DUR_W       = kas_pkg::DUR_W;
    localparam int DELAY_W     = kas_pkg::DELAY_W;
    localparam int ADDR_W      = kas_pkg::ADDR_W;
    localparam int DATA_W      = kas_pkg::DATA_W;
    localparam int IN_W        = kas_pkg::IN_W;
    localparam int OUT_W       = kas_pkg::OUT_W;

    localparam int CNT_BITS    = 8;
    localparam int DLY_STAGES  = 3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [CNT_BITS-1:0] RPT_FLAG = 8'h80;

    // One scanner result: held mask, new-key mask and queried duration.
    typedef struct packed {
        logic [NUM_BUTTONS-1:0] held;
        logic [NUM_BUTTONS-1:0] fresh;
        logic [DUR_W-1:0]       duration;
    } t_scan;

    // Clock, reset and DUT ports; the driven inputs are known from time zero.
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [ADDR_W-1:0]    paddr         = '0;
    logic [DATA_W-1:0]    pwdata        = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata  = '0;  // raw_keys[9:0], query_mask[19:10]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;        // held_keys[9:0], new_keys[19:10],
                                               // queried_duration[35:20]

    // Scoreboard model state and its copy of the registers.
    logic [NUM_BUTTONS-1:0] key_prev_held;
    logic [DUR_W-1:0]       hold_ticks   [NUM_BUTTONS];
    logic [CNT_BITS-1:0]    repeat_count [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] sample_pipe  [DLY_STAGES];
    logic [NUM_BUTTONS-1:0] cfg_enable;
    logic [DELAY_W-1:0]     cfg_initial;
    logic [DELAY_W-1:0]     cfg_repeat;
    logic                   cfg_delayed;

    t_scan expected_scans[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int failures       = 0;
    int ticks_sent     = 0;
    int scans_checked  = 0;
    int repeat_fires   = 0;
    int cycles         = 0;

    key_autorepeat_scanner #(
        .COUNTER_BITS (CNT_BITS),
        .DELAY_STAGES (DLY_STAGES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Run limit in case the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycles, expected_scans.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Advances the model by one frame tick and returns the expected result.
    function automatic t_scan predict_scan(input logic [NUM_BUTTONS-1:0] raw,
                                           input logic [NUM_BUTTONS-1:0] qry);
        t_scan                  res;
        logic [NUM_BUTTONS-1:0] sample;
        logic [NUM_BUTTONS-1:0] held;
        logic [NUM_BUTTONS-1:0] fresh;
        logic [CNT_BITS-1:0]    cnt;
        sample = ~raw;
        // The delay line only shifts in delayed mode.
        if (cfg_delayed) begin
            held = sample_pipe[0];
            for (int s = 0; s < DLY_STAGES - 1; s++)
                sample_pipe[s] = sample_pipe[s + 1];
            sample_pipe[DLY_STAGES - 1] = sample;
        end else begin
            held = sample;
        end
        fresh = held & ~key_prev_held;
        key_prev_held = held;

        for (int b = 0; b < NUM_BUTTONS; b++) begin
            hold_ticks[b] = held[b] ? hold_ticks[b] + 1'b1 : '0;
            // A disabled button keeps its repeat count untouched.
            if (!cfg_enable[b])
                continue;
            if (!held[b]) begin
                repeat_count[b] = '0;
            end else if (repeat_count[b][CNT_BITS-1]) begin
                cnt = repeat_count[b] + 1'b1;
                if (cnt[CNT_BITS-2:0] >= cfg_repeat) begin
                    cnt = RPT_FLAG;
                    fresh[b] = 1'b1;
                    repeat_fires++;
                end
                repeat_count[b] = cnt;
            end else begin
                cnt = repeat_count[b] + 1'b1;
                if (cnt >= {1'b0, cfg_initial}) begin
                    cnt = RPT_FLAG;
                    fresh[b] = 1'b1;
                    repeat_fires++;
                end
                repeat_count[b] = cnt;
            end
        end

        // The lowest queried button wins, so scan from the top down.
        res.duration = '0;
        for (int b = NUM_BUTTONS - 1; b >= 0; b--)
            if (qry[b])
                res.duration = hold_ticks[b];
        res.held  = held;
        res.fresh = fresh;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [DUR_W-1:0] want,
                               input logic [DUR_W-1:0] got);
        if (want !== got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    // Result side: random stalls and in-order comparison.
    always @(posedge i_clk) begin : scan_checker
        t_scan want;
        t_scan got;
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.held     = m_axis_tdata[9:0];
            got.fresh    = m_axis_tdata[19:10];
            got.duration = m_axis_tdata[35:20];
            if (expected_scans.size() == 0) begin
                failures++;
                $display("%0t: unexpected result transaction, expected none, actual %0h",
                         $time, m_axis_tdata);
            end else begin
                want = expected_scans.pop_front();
                check_field("held_keys", DUR_W'(want.held), DUR_W'(got.held));
                check_field("new_keys", DUR_W'(want.fresh), DUR_W'(got.fresh));
                check_field("queried_duration", want.duration, got.duration);
                scans_checked++;
            end
        end
    end

    // Sends one tick, with an optional idle gap first, and records its result.
    task automatic send_tick(input logic [NUM_BUTTONS-1:0] raw,
                             input logic [NUM_BUTTONS-1:0] qry);
        int gap;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, qry, raw};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_scans.push_back(predict_scan(raw, qry));
        ticks_sent++;
    endtask

    // Holds a fixed set of buttons for a number of ticks.
    task automatic hold_keys(input logic [NUM_BUTTONS-1:0] pressed,
                             input logic [NUM_BUTTONS-1:0] qry, input int count);
        for (int n = 0; n < count; n++)
            send_tick(~pressed, qry);
    endtask

    // Stops sending and waits for every outstanding result plus the latency.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_scans.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle until pready. The bus is
    // left selected so that back-to-back writes go straight to the next setup.
    task automatic write_reg(input kas_pkg::t_cfg_reg idx,
                             input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            kas_pkg::REG_ENABLE:  cfg_enable  = value[NUM_BUTTONS-1:0];
            kas_pkg::REG_INITIAL: cfg_initial = value[DELAY_W-1:0];
            kas_pkg::REG_REPEAT:  cfg_repeat  = value[DELAY_W-1:0];
            kas_pkg::REG_MODE:    cfg_delayed = value[0];
            default: ;
        endcase
    endtask

    // Writes all registers once the block is idle; upper data bits are junk.
    task automatic set_config(input logic [NUM_BUTTONS-1:0] enable,
                              input logic [DELAY_W-1:0] init_dly,
                              input logic [DELAY_W-1:0] rpt_dly, input logic delayed);
        wait_idle();
        write_reg(kas_pkg::REG_ENABLE, {22'($urandom), enable});
        write_reg(kas_pkg::REG_INITIAL, {25'($urandom), init_dly});
        write_reg(kas_pkg::REG_REPEAT, {25'($urandom), rpt_dly});
        write_reg(kas_pkg::REG_MODE, {31'($urandom), delayed});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Reset values: autorepeat off, direct sampling.
    task automatic test_reset_state();
        send_tick(10'h3FF, 10'h000);
        send_tick(10'h000, 10'h3FF);
        send_tick(10'h000, 10'h200);
        send_tick(10'h3FF, 10'h001);
    endtask

    // Field extremes with zero delays, so every held tick pulses.
    task automatic test_field_extremes();
        set_config(10'h3FF, 7'd0, 7'd0, 1'b0);
        send_tick(10'h000, 10'h200);
        send_tick(10'h000, 10'h001);
        send_tick(10'h155, 10'h2AA);
        send_tick(10'h2AA, 10'h155);
        send_tick(10'h3FE, 10'h000);
        send_tick(10'h1FF, 10'h200);
        send_tick(10'h3FF, 10'h3FF);
        send_tick(10'h000, 10'h300);
    endtask

    // Initial and subsequent repeat timing, and a button disabled mid-hold.
    task automatic test_autorepeat_timing();
        set_config(10'h00F, 7'd4, 7'd2, 1'b0);
        hold_keys(10'h003, 10'h002, 12);
        hold_keys(10'h002, 10'h001, 3);
        hold_keys(10'h000, 10'h3FF, 2);
        hold_keys(10'h004, 10'h004, 2);
        // Register writes leave the counters alone.
        set_config(10'h000, 7'd4, 7'd2, 1'b0);
        hold_keys(10'h004, 10'h004, 3);
        set_config(10'h00F, 7'd4, 7'd2, 1'b0);
        hold_keys(10'h004, 10'h004, 6);
    endtask

    // Delayed sampling, and a detour through direct mode that freezes the line.
    task automatic test_delay_line();
        set_config(10'h3FF, 7'd2, 7'd1, 1'b1);
        send_tick(~10'h001, 10'h001);
        send_tick(~10'h002, 10'h002);
        send_tick(~10'h004, 10'h004);
        send_tick(~10'h008, 10'h3FF);
        send_tick(10'h000, 10'h3FF);
        set_config(10'h3FF, 7'd2, 7'd1, 1'b0);
        hold_keys(10'h300, 10'h100, 3);
        set_config(10'h3FF, 7'd2, 7'd1, 1'b1);
        hold_keys(10'h0F0, 10'h010, 5);
    endtask

    // Maximum delays with two long holds under random noise on other keys.
    task automatic test_long_delays();
        logic [NUM_BUTTONS-1:0] pressed;
        set_config(10'h3FF, 7'd127, 7'd127, 1'b0);
        for (int n = 0; n < 300; n++) begin
            pressed = 10'h208 | (NUM_BUTTONS'($urandom) & 10'h0F3);
            send_tick(~pressed, (n < 150) ? 10'h008 : NUM_BUTTONS'($urandom));
        end
    endtask

    // Random traffic: slowly changing holds with some noise, four idle mixes.
    task automatic test_random_traffic();
        logic [NUM_BUTTONS-1:0] pressed;
        logic [NUM_BUTTONS-1:0] raw;
        logic [NUM_BUTTONS-1:0] qry;
        int seg;
        pressed = '0;
        for (int mix = 0; mix < 4; mix++) begin
            case (mix)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            for (int half = 0; half < 2; half++) begin
                seg = mix * 2 + half;
                if (seg == 0)
                    set_config(10'h3FF, 7'd0, 7'd0, 1'b1);
                else if (seg == 7)
                    set_config(10'h000, 7'd127, 7'd127, 1'b0);
                else
                    set_config(NUM_BUTTONS'($urandom), 7'($urandom_range(0, 15)),
                               7'($urandom_range(0, 7)), 1'($urandom));
                for (int n = 0; n < 112; n++) begin
                    if ($urandom_range(0, 99) < 5) begin
                        raw = NUM_BUTTONS'($urandom);
                    end else begin
                        if ($urandom_range(0, 99) < 15)
                            pressed ^= 10'd1 << $urandom_range(0, NUM_BUTTONS - 1);
                        raw = ~pressed;
                    end
                    case ($urandom_range(0, 3))
                        0: qry = '0;
                        1: qry = 10'd1 << $urandom_range(0, NUM_BUTTONS - 1);
                        default: qry = NUM_BUTTONS'($urandom);
                    endcase
                    send_tick(raw, qry);
                    // Let the pipeline empty once in the middle of a run.
                    if (mix == 1 && n == 80)
                        wait_idle();
                end
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        key_prev_held = '0;
        cfg_enable    = '0;
        cfg_initial   = '0;
        cfg_repeat    = '0;
        cfg_delayed   = 1'b0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            hold_ticks[b]   = '0;
            repeat_count[b] = '0;
        end
        for (int s = 0; s < DLY_STAGES; s++)
            sample_pipe[s] = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_field_extremes();
        test_autorepeat_timing();
        test_delay_line();
        test_long_delays();
        test_random_traffic();

        wait_idle();
        if (expected_scans.size() != 0)
            failures++;

        $display("Scanned %0d ticks, checked %0d results, %0d autorepeat pulses predicted.",
                 ticks_sent, scans_checked, repeat_fires);
        $display("Run spanned direct and delayed sampling, zero and maximum delays, ",
                 "long holds and four idle and stall mixes.");
        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d failures", failures);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/kas_pkg.sv
hdl/kas_lane.sv
hdl/kas_merge.sv
hdl/key_autorepeat_scanner.sv
dv/tb.sv
